@@ rtl/core/jsu_pkg.sv @@
// Shared widths, symbol encodings and code table of the Jacobi symbol unit.
`default_nettype none

package jsu_pkg;

  localparam int VALUE_BITS_DEF = 31;   // default working width of the modulus
  localparam int NUM_W          = 32;   // numerator width
  localparam int MOD_W          = 31;   // modulus register width

  // Symbol in two's complement
  localparam logic signed [1:0] SYM_NEG  = 2'sb11;
  localparam logic signed [1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [1:0] SYM_POS  = 2'sb01;

  // Two-bit code: -1 -> 0, 0 -> 1, +1 -> 2
  localparam logic [1:0] CODE_TABLE [3] = '{2'd0, 2'd1, 2'd2};

  // Engine control and status
  typedef struct packed {
    logic start;   // load a new numerator
    logic take;    // result consumed
  } jsu_ctl_t;

  typedef struct packed {
    logic              idle;
    logic              done;
    logic signed [1:0] sym;
  } jsu_sts_t;

  function automatic logic [1:0] code_of(input logic signed [1:0] s);
    logic [1:0] c;
    c = CODE_TABLE[1];
    unique case (s)
      SYM_NEG:  c = CODE_TABLE[0];
      SYM_POS:  c = CODE_TABLE[2];
      default:  c = CODE_TABLE[1];
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/jsu_engine.sv @@
// Iterative binary Jacobi reduction: one shared subtract/compare per cycle.
`default_nettype none

module jsu_engine
  import jsu_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire jsu_ctl_t                ctl,
  input  wire logic signed [NUM_W-1:0] num_in,
  input  wire logic [MOD_W-1:0]        mod_in,
  output jsu_sts_t                     sts
);

  localparam int AW = (VALUE_BITS > NUM_W) ? VALUE_BITS : NUM_W;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t                 state_r;
  logic [AW-1:0]          a_r;
  logic [VALUE_BITS-1:0]  n_r;
  logic                   neg_r;     // running sign is -1
  logic signed [1:0]      sym_r;

  logic [NUM_W-1:0]                 num_abs;
  logic [MOD_W+VALUE_BITS-1:0]      mod_ext;
  logic [VALUE_BITS-1:0]            n_init;
  logic [AW+NUM_W-1:0]              abs_ext;
  logic [AW-1:0]                    n_wide;
  logic [AW-1:0]                    diff;
  logic                             a_lt_n;
  logic                             a_zero;
  logic                             n_bad;

  always_comb begin
    num_abs = num_in[NUM_W-1] ? (~num_in + 1'b1) : num_in;
    abs_ext = {{AW{1'b0}}, num_abs};
    mod_ext = {{VALUE_BITS{1'b0}}, mod_in};
    n_init  = mod_ext[VALUE_BITS-1:0];
    n_bad   = ~n_init[0];                 // even, zero included
    n_wide  = AW'(n_r);
    // one subtractor: the borrow out is the a < n compare
    {a_lt_n, diff} = {1'b0, a_r} - {1'b0, n_wide};
    a_zero  = (a_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sym_r   <= SYM_ZERO;
      neg_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (ctl.start) begin
            a_r   <= abs_ext[AW-1:0];
            n_r   <= n_init;
            // (-1/n) = -1 when n = 3 mod 4
            neg_r <= num_in[NUM_W-1] & (n_init[1:0] == 2'b11);
            if (n_bad) begin
              sym_r   <= SYM_ZERO;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (a_zero) begin
            if (n_r == VALUE_BITS'(1)) begin
              sym_r <= neg_r ? SYM_NEG : SYM_POS;
            end else begin
              sym_r <= SYM_ZERO;
            end
            state_r <= ST_DONE;
          end else if (!a_r[0]) begin
            // factor of two: (2/n) = -1 when n = 3 or 5 mod 8
            a_r <= a_r >> 1;
            if (n_r[2:0] == 3'd3 || n_r[2:0] == 3'd5) begin
              neg_r <= ~neg_r;
            end
          end else if (a_lt_n) begin
            // reciprocity swap
            a_r <= n_wide;
            n_r <= a_r[VALUE_BITS-1:0];
            if (a_r[1:0] == 2'b11 && n_r[1:0] == 2'b11) begin
              neg_r <= ~neg_r;
            end
          end else begin
            a_r <= diff;
          end
        end
        ST_DONE: begin
          if (ctl.take) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    sts.idle = (state_r == ST_IDLE);
    sts.done = (state_r == ST_DONE);
    sts.sym  = sym_r;
  end

  // Modulus stays odd for the whole reduction
  a_n_odd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> n_r[0])
    else $error("jsu_engine: even modulus during reduction");

  // A swap always leaves a above n
  a_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && !a_zero && a_r[0] && a_lt_n) |=> (a_r > AW'(n_r)))
    else $error("jsu_engine: swap did not order operands");

  // Finished symbol is a legal value
  a_sym: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> sym_r != 2'sb10)
    else $error("jsu_engine: illegal symbol");

  // Start is only issued to an idle engine
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> state_r == ST_IDLE)
    else $error("jsu_engine: start while busy");

endmodule

`default_nettype wire

@@ rtl/core/jacobi_symbol_unit_top.sv @@
// Top level of the Jacobi symbol unit: stream ports, modulus register, output stage.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata[31:0] numerator (signed), tlast is_last
//  out_    | out | out_tvalid/tready  | tdata[1:0] symbol, [3:2] code_bits, tlast
//  cfg_    | in  | cfg_we             | cfg_wdata[30:0] modulus P
//
// One item at a time: the accepting edge loads the engine, then a data-dependent
// reduction (one shift, swap or subtract per cycle on the shared subtractor), a step
// that sees the zero remainder, and the hand-off of the result to the output register
// once that register is empty or draining.
// Even or zero modulus skips the reduction and goes straight to the hand-off.
// in_tready is high only while the engine is idle; the output register lets the
// engine take the next item while a result waits on out_tready.
// Synchronous active-low reset; modulus resets to 3.
`default_nettype none

module jacobi_symbol_unit_top
  import jsu_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input items
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [31:0]      in_tdata,    // [31:0] numerator
  input  wire logic             in_tlast,    // is_last
  // results
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata,   // [1:0] symbol, [3:2] code_bits, [7:4] zero
  output logic                  out_tlast,   // last_out
  // modulus register
  input  wire logic             cfg_we,
  input  wire logic [MOD_W-1:0] cfg_wdata
);

  logic [MOD_W-1:0]  mod_r;
  logic              last_r;       // tlast of the item in the engine
  logic              out_valid_r;
  logic signed [1:0] out_sym_r;
  logic [1:0]        out_code_r;
  logic              out_last_r;

  jsu_ctl_t ctl;
  jsu_sts_t sts;
  logic     in_fire;
  logic     take;

  assign in_tready = sts.idle;
  assign in_fire   = in_tvalid & sts.idle;
  // result moves to the output register when it is empty or draining
  assign take      = sts.done & (~out_valid_r | out_tready);

  always_comb begin
    ctl.start = in_fire;
    ctl.take  = take;
  end

  jsu_engine #(
    .VALUE_BITS (VALUE_BITS)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .num_in (in_tdata),
    .mod_in (mod_r),
    .sts    (sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= MOD_W'(3);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mod_r <= cfg_wdata;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      last_r <= in_tlast;
    end
    if (take) begin
      out_sym_r  <= sts.sym;
      out_code_r <= code_of(sts.sym);
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_code_r, out_sym_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
